// ===== rtl/argb_ramp_pkg.sv =====
// ----------------------------------------------------------------------------
// argb_ramp_pkg
// Shared types and constants for the ARGB colour ramp generator.
// ----------------------------------------------------------------------------
package argb_ramp_pkg;

  localparam int ARGB_W    = 32;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 4;
  localparam int CH_IDX_W  = 2;
  localparam int COUNT_W   = 7;
  localparam int POS_OUT_W = 6;
  localparam int DIV_CNT_W = $clog2(CH_W);

  localparam logic [CH_IDX_W-1:0]  CH_LAST      = CH_IDX_W'(NUM_CH - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(CH_W - 1);

  // Control from the sequencer to the channel lanes
  typedef struct packed {
    logic                init;      // load start colour, clear steps
    logic                advance;   // move every lane to the next ramp entry
    logic                step_wr;   // store a per-channel step from the divider
    logic [CH_IDX_W-1:0] step_ch;
    logic                step_neg;  // end channel below start channel
  } lane_ctrl_t;

endpackage

// ===== rtl/argb_ramp_div.sv =====
// ----------------------------------------------------------------------------
// argb_ramp_div
// Restoring divider, one quotient bit per cycle: 8-bit dividend over the
// interval count. Shared by all four colour channels.
// ----------------------------------------------------------------------------
module argb_ramp_div import argb_ramp_pkg::*; #(
  parameter int PW = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [CH_W-1:0] dividend_i,
  input  logic [PW-1:0]   divisor_i,
  output logic            done_o,
  output logic [CH_W-1:0] quo_o,
  output logic [PW-1:0]   rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CH_W-1:0]      acc_q, acc_d;
  logic [PW-1:0]        rem_q, rem_d;

  logic [PW:0] rem_sh;
  logic [PW:0] rem_sub;
  logic        fits;

  always_comb begin
    rem_sh  = {rem_q, acc_q[CH_W-1]};
    fits    = (rem_sh >= {1'b0, divisor_i});
    rem_sub = rem_sh - {1'b0, divisor_i};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // quotient bits shift in as dividend bits shift out
      acc_d = {acc_q[CH_W-2:0], fits};
      rem_d = fits ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;
  assign rem_o  = rem_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

// ===== rtl/argb_ramp_lanes.sv =====
// ----------------------------------------------------------------------------
// argb_ramp_lanes
// Four channel lanes, each a quotient/remainder accumulator stepping the
// rounded interpolant by a fixed step per ramp entry.
// ----------------------------------------------------------------------------
module argb_ramp_lanes import argb_ramp_pkg::*; #(
  parameter int PW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  logic [PW-1:0]     k_i,
  input  logic [ARGB_W-1:0] start_color_i,
  input  logic [CH_W-1:0]   quo_i,
  input  logic [PW-1:0]     rem_i,
  output logic [ARGB_W-1:0] color_o
);

  localparam int RW = PW + 2;

  // remainder is held against 2K, value q = floor((2*num + K) / 2K)
  logic [CH_W-1:0] q_q  [NUM_CH];
  logic [RW-1:0]   r_q  [NUM_CH];
  logic [CH_W-1:0] dq_q [NUM_CH];
  logic [RW-1:0]   dr_q [NUM_CH];

  logic [RW-1:0]   k2;
  logic [RW-1:0]   k_ext;
  logic [RW-1:0]   rem2;
  logic [CH_W-1:0] dq_new;
  logic [RW-1:0]   dr_new;
  logic [RW-1:0]   r_sum [NUM_CH];
  logic            wrap  [NUM_CH];

  always_comb begin
    k2    = RW'({k_i, 1'b0});
    k_ext = RW'(k_i);
    rem2  = RW'({rem_i, 1'b0});
    // a falling channel steps by -(q+1) with remainder 2K-2r, unless exact
    if (!ctrl_i.step_neg) begin
      dq_new = quo_i;
      dr_new = rem2;
    end else if (rem_i == '0) begin
      dq_new = -quo_i;
      dr_new = '0;
    end else begin
      dq_new = ~quo_i;
      dr_new = k2 - rem2;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      r_sum[c] = r_q[c] + dr_q[c];
      wrap[c]  = (r_sum[c] >= k2);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (ctrl_i.init) begin
        q_q[c]  <= start_color_i[c*CH_W +: CH_W];
        r_q[c]  <= k_ext;
        dq_q[c] <= '0;
        dr_q[c] <= '0;
      end else begin
        if (ctrl_i.step_wr && (ctrl_i.step_ch == CH_IDX_W'(c))) begin
          dq_q[c] <= dq_new;
          dr_q[c] <= dr_new;
        end
        if (ctrl_i.advance) begin
          q_q[c] <= q_q[c] + dq_q[c] + CH_W'(wrap[c]);
          r_q[c] <= wrap[c] ? (r_sum[c] - k2) : r_sum[c];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      color_o[c*CH_W +: CH_W] = q_q[c];
    end
  end

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance |-> (r_q[0] < k2 && r_q[1] < k2 && r_q[2] < k2 && r_q[3] < k2))
    else $error("lane remainder out of range");

endmodule

// ===== rtl/argb_color_ramp_generator_top.sv =====
// ----------------------------------------------------------------------------
// argb_color_ramp_generator_top
// ARGB colour ramp: a start colour, an end colour and a count in, that many
// evenly spaced colours out, the last one marked.
// ----------------------------------------------------------------------------
// A request of N colours (saturated to MAX_COLORS) is taken, then the S_INIT
// state loads the lanes. For N of 3 or more, a single shared restoring divider
// works out the per-channel step, one channel after another (issue, 8 quotient
// bits, hand-over). After that one colour word leaves per cycle while the
// output is not stalled. A request with N of 0 gives no words. A new request
// is taken only once the previous one has issued its last word into the output
// register.
module argb_color_ramp_generator_top import argb_ramp_pkg::*; #(
  parameter int MAX_COLORS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ARGB_W-1:0]    start_color_i,
  input  logic [ARGB_W-1:0]    end_color_i,
  input  logic [COUNT_W-1:0]   color_count_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ARGB_W-1:0]    ramp_color_o,
  output logic [POS_OUT_W-1:0] ramp_position_o,
  output logic                 last_color_o
);

  localparam int PW = $clog2(MAX_COLORS);
  localparam int NW = PW + 1;
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_COLORS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_EMIT
  } state_e;

  state_e              state_q, state_d;
  logic [CH_IDX_W-1:0] ch_q, ch_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [PW-1:0]       k_q, k_d;
  logic                many_q, many_d;
  logic                out_valid_q, out_valid_d;
  logic [ARGB_W-1:0]   color_q, color_d;
  logic [CW-1:0]       opos_q, opos_d;
  logic                last_q, last_d;

  logic [ARGB_W-1:0] sc_q, ec_q;

  logic          accept;
  logic [CW-1:0] cnt_ext;
  logic [NW-1:0] n_sat;
  logic [NW-1:0] n_m1;

  logic [CH_W-1:0] s_b, e_b, mag;
  logic            neg;
  logic            div_start, div_done;
  logic [CH_W-1:0] div_quo;
  logic [PW-1:0]   div_rem;

  lane_ctrl_t        lane_ctrl;
  logic [ARGB_W-1:0] lane_color;

  logic out_load, pos_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cnt_ext = CW'(color_count_i);
    n_sat   = NW'((cnt_ext > MaxCount) ? MaxCount : cnt_ext);
    n_m1    = n_sat - NW'(1);
  end

  // channel operands for the divider
  always_comb begin
    s_b = sc_q[ch_q*CH_W +: CH_W];
    e_b = ec_q[ch_q*CH_W +: CH_W];
    neg = (e_b < s_b);
    mag = neg ? (s_b - e_b) : (e_b - s_b);
  end

  assign div_start = (state_q == S_DIV_GO);
  assign pos_last  = (pos_q == k_q);
  assign out_load  = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    lane_ctrl.init     = (state_q == S_INIT);
    lane_ctrl.advance  = out_load && !pos_last;
    lane_ctrl.step_wr  = div_done;
    lane_ctrl.step_ch  = ch_q;
    lane_ctrl.step_neg = neg;
  end

  argb_ramp_div #(
    .PW (PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (k_q),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  argb_ramp_lanes #(
    .PW (PW)
  ) u_lanes (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (lane_ctrl),
    .k_i           (k_q),
    .start_color_i (sc_q),
    .quo_i         (div_quo),
    .rem_i         (div_rem),
    .color_o       (lane_color)
  );

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    pos_d       = pos_q;
    k_d         = k_q;
    many_d      = many_q;
    out_valid_d = out_valid_q && out_stall_i;
    color_d     = color_q;
    opos_d      = opos_q;
    last_d      = last_q;

    case (state_q)
      S_IDLE: begin
        if (accept && (n_sat != '0)) begin
          k_d     = n_m1[PW-1:0];
          many_d  = (n_sat > NW'(2));
          pos_d   = '0;
          ch_d    = '0;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        state_d = many_q ? S_DIV_GO : S_EMIT;
      end
      S_DIV_GO: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (ch_q == CH_LAST) begin
            state_d = S_EMIT;
          end else begin
            ch_d    = ch_q + CH_IDX_W'(1);
            state_d = S_DIV_GO;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          opos_d      = CW'(pos_q);
          last_d      = pos_last;
          if (pos_q == '0) begin
            color_d = sc_q;
          end else if (pos_last) begin
            color_d = ec_q;
          end else begin
            color_d = lane_color;
          end
          if (pos_last) begin
            state_d = S_IDLE;
          end else begin
            pos_d = pos_q + PW'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      pos_q       <= '0;
      k_q         <= '0;
      many_q      <= 1'b0;
      out_valid_q <= 1'b0;
      color_q     <= '0;
      opos_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      many_q      <= many_d;
      out_valid_q <= out_valid_d;
      color_q     <= color_d;
      opos_q      <= opos_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sc_q <= start_color_i;
      ec_q <= end_color_i;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ramp_color_o    = color_q;
  assign ramp_position_o = opos_q[POS_OUT_W-1:0];
  assign last_color_o    = last_q;

  a_empty_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && color_count_i == '0) |=> !in_stall_o)
    else $error("empty request left the block busy");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_WAIT))
    else $error("divider result outside wait state");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && pos_last) |=> (state_q == S_IDLE && out_valid_q && last_q))
    else $error("final word did not end the request");

endmodule

// ===== tb/argb_color_ramp_generator_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// argb_color_ramp_generator_top_tb
// Self-checking bench for the ARGB colour ramp generator: directed ramps at
// the count and colour extremes, then random requests with random idling on
// both sides, every output word checked against an in-bench ramp predictor.
// ----------------------------------------------------------------------------
module argb_color_ramp_generator_top_tb;
  import argb_ramp_pkg::*;

  localparam int RAMP_MAX     = 64;
  localparam int RANDOM_ITEMS = 196;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [ARGB_W-1:0]    color;
    logic [POS_OUT_W-1:0] pos;
    logic                 last;
  } ramp_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ARGB_W-1:0]    start_color_i;
  logic [ARGB_W-1:0]    end_color_i;
  logic [COUNT_W-1:0]   color_count_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ARGB_W-1:0]    ramp_color_o;
  logic [POS_OUT_W-1:0] ramp_position_o;
  logic                 last_color_o;

  // high during a stretch where neither side idles
  logic        calm;
  int unsigned cycle_cnt;

  argb_color_ramp_generator_top #(
    .MAX_COLORS(RAMP_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_color_i  (start_color_i),
    .end_color_i    (end_color_i),
    .color_count_i  (color_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .ramp_color_o   (ramp_color_o),
    .ramp_position_o(ramp_position_o),
    .last_color_o   (last_color_o)
  );

  class color_ramp_checker;
    ramp_word_t  pending_words[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // rounded half up: floor((2*(s*(iv-i) + e*i) + iv) / (2*iv))
    function logic [CH_W-1:0] blend_channel(int unsigned s, int unsigned e,
                                            int unsigned i, int unsigned iv);
      int unsigned num;
      num = s * (iv - i) + e * i;
      return CH_W'((2 * num + iv) / (2 * iv));
    endfunction

    function logic [ARGB_W-1:0] blend_color(logic [ARGB_W-1:0] sc,
                                            logic [ARGB_W-1:0] ec,
                                            int unsigned i, int unsigned iv);
      logic [ARGB_W-1:0] res;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        res[ch*CH_W +: CH_W] = blend_channel(sc[ch*CH_W +: CH_W], ec[ch*CH_W +: CH_W],
                                             i, iv);
      end
      return res;
    endfunction

    function void note_request(logic [ARGB_W-1:0] sc, logic [ARGB_W-1:0] ec,
                               logic [COUNT_W-1:0] cnt);
      int unsigned n;
      ramp_word_t  w;
      n = (cnt > RAMP_MAX) ? RAMP_MAX : cnt;
      for (int unsigned i = 0; i < n; i++) begin
        if (i == 0) begin
          w.color = sc;
        end else if (i == n - 1) begin
          w.color = ec;
        end else begin
          w.color = blend_color(sc, ec, i, n - 1);
        end
        w.pos  = POS_OUT_W'(i);
        w.last = (i == n - 1);
        pending_words = {pending_words, w};
      end
    endfunction

    function void check_word(logic [ARGB_W-1:0] color, logic [POS_OUT_W-1:0] pos,
                             logic last);
      ramp_word_t exp_w;
      if (pending_words.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("unexpected word: colour %h pos %0d last %0b", color, pos, last);
        end
        return;
      end
      exp_w = pending_words.pop_front();
      if (exp_w.color !== color || exp_w.pos !== pos || exp_w.last !== last) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("word mismatch: exp colour %h pos %0d last %0b, %s",
                   exp_w.color, exp_w.pos, exp_w.last,
                   $sformatf("got colour %h pos %0d last %0b", color, pos, last));
        end
      end
    endfunction
  endclass

  color_ramp_checker ramp_book = new();

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ARGB_W-1:0] pick_color();
    logic [ARGB_W-1:0] c;
    c = $urandom();
    if ($urandom_range(0, 5) == 0) begin
      // each channel at one of its extremes
      for (int ch = 0; ch < NUM_CH; ch++) begin
        c[ch*CH_W +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
    end
    return c;
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 65) return COUNT_W'($urandom_range(1, 8));
    if (r < 85) return COUNT_W'($urandom_range(9, 30));
    if (r < 95) return COUNT_W'($urandom_range(31, RAMP_MAX));
    return COUNT_W'($urandom_range(RAMP_MAX + 1, 127));
  endfunction

  task automatic send_request(input logic [ARGB_W-1:0] sc, input logic [ARGB_W-1:0] ec,
                              input logic [COUNT_W-1:0] cnt);
    int unsigned gap;
    gap = idle_len();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) begin
        // junk on the payload while idle
        start_color_i = $urandom();
        end_color_i   = $urandom();
        color_count_i = COUNT_W'($urandom());
        @(negedge clk_i);
      end
    end
    start_color_i = sc;
    end_color_i   = ec;
    color_count_i = cnt;
    in_valid_i    = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ramp_book.note_request(sc, ec, cnt);
  endtask

  // output stall bursts
  initial begin : out_stall_gen
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ramp_book.check_word(ramp_color_o, ramp_position_o, last_color_o);
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d words outstanding",
             cycle_cnt, ramp_book.pending_words.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    calm          = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    start_color_i = '0;
    end_color_i   = '0;
    color_count_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // count zero, one and two
    send_request(32'h1234_5678, 32'h9ABC_DEF0, 7'd0);
    send_request(32'hDEAD_BEEF, 32'h0000_0000, 7'd1);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 7'd2);
    // shortest interpolated ramp, half-way values round up
    send_request(32'h0000_0000, 32'h0101_0101, 7'd3);
    send_request(32'h0101_0101, 32'h0000_0000, 7'd3);
    send_request(32'h0002_0002, 32'h0200_0200, 7'd5);
    // full swing both ways, mixed channel directions
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 7'd64);
    send_request(32'hFFFF_FFFF, 32'h0000_0000, 7'd63);
    send_request(32'h00FF_00FF, 32'hFF00_FF00, 7'd17);
    send_request(32'h8040_C020, 32'h8040_C020, 7'd9);
    // counts past the maximum saturate
    send_request(32'h0000_00FF, 32'hFF00_0000, 7'd65);
    send_request(32'hFF00_FF00, 32'h00FF_00FF, 7'd127);
    send_request(32'h7F80_017E, 32'h807F_FE81, 7'd96);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd4);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 80 && k < 120);
      if ($urandom_range(0, 9) == 0) begin
        send_request(pick_color(), pick_color(), COUNT_W'($urandom_range(1, 2)));
      end else begin
        send_request(pick_color(), pick_color(), pick_count());
      end
    end
    calm = 1'b0;
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (ramp_book.pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ramp_book.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
